// ===== hw/rtl/agga_pkg.sv =====
// Shared types, constants and helpers for the affine-gap global alignment block.
// Used by affine_gap_global_alignment; depends on nothing else.
package agga_pkg;

    localparam int QUERY_MAX_DEF = 64;
    localparam int SCORE_W       = 16;
    localparam int COL_W         = 16;
    localparam int ROW_IDX_W     = 6;
    localparam int SYM_W         = 2;
    localparam int ACT_W         = 2;
    localparam int COST_W        = 7;
    localparam int GAP_W         = 6;
    localparam int LEN_W         = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH        = 3'd0,
        CFG_MISMATCH     = 3'd1,
        CFG_GAP_OPEN     = 3'd2,
        CFG_GAP_EXTEND   = 3'd3,
        CFG_QUERY_LENGTH = 3'd4
    } cfg_reg_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_START  = 2'd1,
        ACT_COLUMN = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_PREP,
        ST_RUN
    } state_t;

    typedef logic signed [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [ROW_IDX_W-1:0] query_index;
        logic [SYM_W-1:0]     symbol;
    } req_t;

    typedef struct packed {
        score_t               cell_score;
        logic [ROW_IDX_W-1:0] row_index;
        logic [COL_W-1:0]     column_index;
        logic                 last_row;
    } res_t;

    // clamp to the signed score range
    function automatic score_t sat_score(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = signed'(32'((64'd1 << (SCORE_W - 1)) - 64'd1));
        lo = -hi - 32'sd1;
        if (v > hi) begin
            return SCORE_W'(hi);
        end
        if (v < lo) begin
            return SCORE_W'(lo);
        end
        return SCORE_W'(v);
    endfunction

endpackage

// ===== hw/rtl/affine_gap_global_alignment.sv =====
// Affine-gap global alignment engine: query/H/E row stores and a shared cell unit.
// Depends on agga_pkg (types, constants, saturation helper).
// A start word runs an init sweep over all rows of the H and E row stores before the next word is taken.
// Column word: after a prep state, one row per cycle through the single
// shared cell unit; a column of L rows holds the input through prep, the L steps and the E
// writeback. Output stalls freeze the cell unit. Reset clears control state and runs a
// clearing pass over all QUERY_MAX rows of the H and E stores before the first word is taken.
module affine_gap_global_alignment
    import agga_pkg::*;
#(
    parameter int QUERY_MAX = QUERY_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res
);

    localparam int ROW_W  = $clog2(QUERY_MAX);
    localparam int PROD_W = COL_W + GAP_W;
    localparam int CALC_W = SCORE_W + 2;
    localparam int ACC_W  = GAP_W + $clog2(QUERY_MAX + 2) + 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(QUERY_MAX - 1);

    // configuration registers
    logic signed [COST_W-1:0] match_reg;
    logic signed [COST_W-1:0] mismatch_reg;
    logic [GAP_W-1:0]         gap_open_reg;
    logic [GAP_W-1:0]         gap_extend_reg;
    logic [LEN_W-1:0]         query_length_reg;

    // sequencer
    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   sweep_reg, sweep_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               res_valid_reg, res_valid_next;
    logic               e_pend_reg, e_pend_next;

    // datapath
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0]  jr_reg, jr_next;
    logic [ROW_W-1:0]   last_reg, last_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    score_t             diag_reg, diag_next;
    score_t             hup_reg, hup_next;
    score_t             fup_reg, fup_next;
    logic [GAP_W:0]     qr_reg, qr_next;
    logic [GAP_W-1:0]   r_reg, r_next;
    score_t             eh_reg, eh_next;
    score_t             eold_reg, eold_next;
    logic [ROW_W-1:0]   erow_reg, erow_next;
    res_t               res_reg, res_next;

    // row stores
    logic [SYM_W-1:0]   qry_mem [QUERY_MAX];
    score_t             h_mem   [QUERY_MAX];
    score_t             e_mem   [QUERY_MAX];
    logic [SYM_W-1:0]   qry_rd_reg;
    score_t             h_rd_reg;
    score_t             e_rd_reg;

    logic               q_we;
    logic [ROW_W-1:0]   q_waddr;
    logic               h_we;
    logic [ROW_W-1:0]   h_waddr;
    score_t             h_wdata;
    logic               e_we;
    logic [ROW_W-1:0]   e_waddr;
    score_t             e_wdata;
    logic               rd_en;
    logic [ROW_W-1:0]   rd_addr;

    logic               req_fire;
    logic               step;
    logic               is_last;
    logic [31:0]        len32;

    // shared cell unit signals
    logic signed [COST_W-1:0] sc;
    logic signed [CALC_W-1:0] qr_c, r_c, sc_c;
    logic signed [CALC_W-1:0] f_up, f_ext, f_min;
    logic signed [CALC_W-1:0] d_val, h_min, e_a, e_b, e_min;
    score_t                   f_val, h_val, e_val;

    // boundary terms
    logic signed [31:0] q32, r32, jr32, acc32;

    //------------------------------------------------------------------
    // Configuration port: no handshake, write lands at the clock edge.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg        <= '0;
            mismatch_reg     <= COST_W'(1);
            gap_open_reg     <= GAP_W'(1);
            gap_extend_reg   <= GAP_W'(1);
            query_length_reg <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MATCH:        match_reg        <= signed'(cfg_data[COST_W-1:0]);
                CFG_MISMATCH:     mismatch_reg     <= signed'(cfg_data[COST_W-1:0]);
                CFG_GAP_OPEN:     gap_open_reg     <= cfg_data[GAP_W-1:0];
                CFG_GAP_EXTEND:   gap_extend_reg   <= cfg_data[GAP_W-1:0];
                CFG_QUERY_LENGTH: query_length_reg <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Handshake. Input is taken only in IDLE and only once the E
    // writeback of the previous column has landed, so row 0 of the next
    // column never reads a stale E value.
    //------------------------------------------------------------------
    assign req_ready = (state_reg == ST_IDLE) && !e_pend_reg;
    assign req_fire  = req_valid && req_ready;
    // cell unit advances only if the output register is free or draining
    assign step      = (state_reg == ST_RUN) && (!res_valid_reg || res_ready);
    assign is_last   = (row_reg == last_reg);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    //------------------------------------------------------------------
    // Shared cell unit: one matrix cell per step.
    //   F = min(Hup + q + r, Fup + r)
    //   H = min(diag + score, Eold, F)
    // E = min(H + q + r, Eold + r) is finished in the following cycle from the
    // registered H, so the per-step chain stays at one add/compare level
    // per term.
    //------------------------------------------------------------------
    assign sc    = (qry_rd_reg == sym_reg) ? match_reg : mismatch_reg;
    assign qr_c  = signed'(CALC_W'(qr_reg));
    assign r_c   = signed'(CALC_W'(r_reg));
    assign sc_c  = CALC_W'(sc);

    assign f_up  = CALC_W'(hup_reg) + qr_c;
    assign f_ext = CALC_W'(fup_reg) + r_c;
    assign f_min = (f_up < f_ext) ? f_up : f_ext;
    assign f_val = sat_score(32'(f_min));

    assign d_val = CALC_W'(diag_reg) + sc_c;

    always_comb
    begin
        h_min = d_val;
        if (CALC_W'(e_rd_reg) < h_min)
        begin
            h_min = CALC_W'(e_rd_reg);
        end
        if (CALC_W'(f_val) < h_min)
        begin
            h_min = CALC_W'(f_val);
        end
    end
    assign h_val = sat_score(32'(h_min));

    assign e_a   = CALC_W'(eh_reg) + qr_c;
    assign e_b   = CALC_W'(eold_reg) + r_c;
    assign e_min = (e_a < e_b) ? e_a : e_b;
    assign e_val = sat_score(32'(e_min));

    // column boundary: H top = q + (j+1)r, F top = 2q + (j+1)r
    assign q32   = signed'(32'(gap_open_reg));
    assign r32   = signed'(32'(gap_extend_reg));
    assign jr32  = signed'(32'(jr_reg));
    assign acc32 = signed'(32'(acc_reg));

    // effective row count: zero acts as one, clipped to the store depth
    always_comb
    begin
        len32 = 32'(query_length_reg);
        if (len32 == 32'd0)
        begin
            len32 = 32'd1;
        end
        if (len32 > 32'(QUERY_MAX))
        begin
            len32 = 32'(QUERY_MAX);
        end
    end

    //------------------------------------------------------------------
    // Next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_reg == ROW_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.action)
                        ACT_START:  state_next = ST_INIT;
                        ACT_COLUMN: state_next = ST_PREP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:
            begin
                if (sweep_reg == ROW_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (step && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Sequencer outputs and datapath next values
    //------------------------------------------------------------------
    always_comb
    begin
        sweep_next     = sweep_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        acc_next       = acc_reg;
        jr_next        = jr_reg;
        last_next      = last_reg;
        sym_next       = sym_reg;
        diag_next      = diag_reg;
        hup_next       = hup_reg;
        fup_next       = fup_reg;
        qr_next        = qr_reg;
        r_next         = r_reg;
        eh_next        = eh_reg;
        eold_next      = eold_reg;
        erow_next      = erow_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        e_pend_next    = 1'b0;

        q_we    = 1'b0;
        q_waddr = ROW_W'(32'(req.query_index));
        h_we    = 1'b0;
        h_waddr = sweep_reg;
        h_wdata = '0;
        e_we    = e_pend_reg;
        e_waddr = erow_reg;
        e_wdata = e_val;
        rd_en   = 1'b0;
        rd_addr = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                h_we       = 1'b1;
                e_we       = 1'b1;
                e_waddr    = sweep_reg;
                e_wdata    = '0;
                sweep_next = sweep_reg + ROW_W'(1);
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.action)
                        ACT_LOAD:
                        begin
                            // loads past the store depth are dropped
                            q_we = (32'(req.query_index) < 32'(QUERY_MAX));
                        end
                        ACT_START:
                        begin
                            col_next   = '0;
                            sweep_next = '0;
                            acc_next   = ACC_W'(gap_open_reg) + ACC_W'(gap_extend_reg);
                        end
                        ACT_COLUMN:
                        begin
                            jr_next   = PROD_W'(col_reg) * PROD_W'(gap_extend_reg);
                            last_next = ROW_W'(len32 - 32'd1);
                            sym_next  = req.symbol;
                            rd_en     = 1'b1;
                            rd_addr   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                // acc tracks q + (i+1)r for row i of the sweep
                h_we       = 1'b1;
                h_wdata    = sat_score(acc32);
                e_we       = 1'b1;
                e_waddr    = sweep_reg;
                e_wdata    = sat_score(acc32 + q32);
                acc_next   = acc_reg + ACC_W'(gap_extend_reg);
                sweep_next = sweep_reg + ROW_W'(1);
            end
            ST_PREP:
            begin
                diag_next = (col_reg == '0) ? '0 : sat_score(q32 + jr32);
                hup_next  = sat_score(q32 + jr32 + r32);
                fup_next  = sat_score(q32 + q32 + jr32 + r32);
                qr_next   = (GAP_W + 1)'(gap_open_reg) + (GAP_W + 1)'(gap_extend_reg);
                r_next    = gap_extend_reg;
                row_next  = '0;
            end
            ST_RUN:
            begin
                if (step)
                begin
                    h_we      = 1'b1;
                    h_waddr   = row_reg;
                    h_wdata   = h_val;
                    diag_next = h_rd_reg;
                    hup_next  = h_val;
                    fup_next  = f_val;
                    // E finishes next cycle
                    e_pend_next = 1'b1;
                    eh_next     = h_val;
                    eold_next   = e_rd_reg;
                    erow_next   = row_reg;

                    res_valid_next        = 1'b1;
                    res_next.cell_score   = h_val;
                    res_next.row_index    = ROW_IDX_W'(32'(row_reg));
                    res_next.column_index = col_reg;
                    res_next.last_row     = is_last;

                    if (is_last)
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = row_reg + ROW_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    //------------------------------------------------------------------
    // Row stores: one write and one registered read per store per cycle
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qry_mem[q_waddr] <= req.symbol;
        end
        if (h_we)
        begin
            h_mem[h_waddr] <= h_wdata;
        end
        if (e_we)
        begin
            e_mem[e_waddr] <= e_wdata;
        end
        if (rd_en)
        begin
            qry_rd_reg <= qry_mem[rd_addr];
            h_rd_reg   <= h_mem[rd_addr];
            e_rd_reg   <= e_mem[rd_addr];
        end
    end

    //------------------------------------------------------------------
    // Registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            res_valid_reg <= 1'b0;
            e_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            res_valid_reg <= res_valid_next;
            e_pend_reg    <= e_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        jr_reg   <= jr_next;
        last_reg <= last_next;
        sym_reg  <= sym_next;
        diag_reg <= diag_next;
        hup_reg  <= hup_next;
        fup_reg  <= fup_next;
        qr_reg   <= qr_next;
        r_reg    <= r_next;
        eh_reg   <= eh_next;
        eold_reg <= eold_next;
        erow_reg <= erow_next;
        res_reg  <= res_next;
    end

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_no_h_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && h_we) |-> (rd_addr != h_waddr))
        else $error("H store read and write hit the same row");

    a_e_wb_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        e_pend_reg |-> !req_ready)
        else $error("input taken while E writeback pending");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (row_reg <= last_reg))
        else $error("row counter ran past the last row");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("result word raised outside a column");

    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_last) |=> (col_reg == $past(col_reg) + COL_W'(1)))
        else $error("column counter did not advance after last row");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for affine_gap_global_alignment: drives load, start and column words
// and checks every emitted H cell, field by field, against a built-in predictor.
// Depends on agga_pkg and the affine_gap_global_alignment RTL.
module tb;
    import agga_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    // start word sweeps QUERY_MAX rows; reset runs a clearing pass of the same length
    localparam int DRAIN_CYCLES = QUERY_MAX_DEF + 8;
    // ~170 words with 64-row columns and stalls, plus 11 settings
    // changes, each with a drain and register writes
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int IDLE_PERCENT = 8;
    localparam int PRINT_LIMIT  = 40;
    localparam int RUN_COLUMNS  = 10;

    // action code with no function; the block must drop it
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_t                  res;

    // shadow of the configuration registers, reset values
    logic signed [COST_W-1:0] match_cost = 7'sd0;
    logic signed [COST_W-1:0] mismatch_cost = 7'sd1;
    logic [GAP_W-1:0]         open_cost = 6'd1;
    logic [GAP_W-1:0]         extend_cost = 6'd1;
    logic [LEN_W-1:0]         rows_in_use = 7'd1;

    // predicted alignment state: query symbols, previous H and E column
    logic [SYM_W-1:0] query_sym [QUERY_MAX_DEF];
    int               h_col [QUERY_MAX_DEF];
    int               e_col [QUERY_MAX_DEF];
    logic [COL_W-1:0] column_count = '0;

    res_t expected_cells [$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   no_idle = 1'b0;

    affine_gap_global_alignment DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int clamp_score(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    // Apply one accepted word to the predicted state and queue the cells it emits.
    function automatic void predict_word(input req_t w);
        longint q;
        longint r;
        longint j;
        longint ms;
        longint mm;
        longint diag;
        longint hup;
        longint fup;
        longint sc;
        longint hold;
        longint eold;
        longint f;
        longint h;
        longint e;
        int     rows;
        int     i;
        res_t   out_cell;
        q = longint'(open_cost);
        r = longint'(extend_cost);
        case (w.action)
            ACT_LOAD:
                query_sym[w.query_index] = w.symbol;
            ACT_START:
            begin
                // left boundary of the matrix, all rows regardless of length
                for (i = 0; i < QUERY_MAX_DEF; i++)
                begin
                    h_col[i] = clamp_score(q + longint'(i + 1) * r);
                    e_col[i] = clamp_score(2 * q + longint'(i + 1) * r);
                end
                column_count = '0;
            end
            ACT_COLUMN:
            begin
                ms = longint'(match_cost);
                mm = longint'(mismatch_cost);
                j = longint'(column_count);
                // top boundary of this column; corner diagonal is zero on column 0
                diag = (j == 0) ? 0 : clamp_score(q + j * r);
                hup = clamp_score(q + (j + 1) * r);
                fup = clamp_score(2 * q + (j + 1) * r);
                rows = int'(rows_in_use);
                if (rows == 0)
                    rows = 1;
                if (rows > QUERY_MAX_DEF)
                    rows = QUERY_MAX_DEF;
                for (i = 0; i < rows; i++)
                begin
                    sc = (query_sym[i] == w.symbol) ? ms : mm;
                    hold = h_col[i];
                    eold = e_col[i];
                    // vertical gap: open from H above or extend F above
                    f = clamp_score((hup + q + r < fup + r) ? hup + q + r : fup + r);
                    h = diag + sc;
                    if (eold < h)
                        h = eold;
                    if (f < h)
                        h = f;
                    h = clamp_score(h);
                    // horizontal gap carried to the next column
                    e = h + q + r;
                    if (eold + r < e)
                        e = eold + r;
                    e = clamp_score(e);
                    h_col[i] = int'(h);
                    e_col[i] = int'(e);
                    diag = hold;
                    hup = h;
                    fup = f;
                    out_cell.cell_score = score_t'(h);
                    out_cell.row_index = ROW_IDX_W'(i);
                    out_cell.column_index = column_count;
                    out_cell.last_row = (i == rows - 1);
                    expected_cells.push_back(out_cell);
                end
                column_count = column_count + 1'b1;
            end
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    function automatic req_t make_word(input logic [ACT_W-1:0] act, input int idx,
                                       input int sym);
        req_t w;
        w.action = act;
        w.query_index = ROW_IDX_W'(idx);
        w.symbol = SYM_W'(sym);
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Send one word. Valid stays high after acceptance so back-to-back words
    // need no lowering; whoever pauses next lowers it.
    task automatic send_word(input req_t w);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        // ready only moves on rising edges: sample it mid-cycle
        @(negedge clk);
        while (!req_ready)
            @(negedge clk);
        @(posedge clk);
        predict_word(w);
    endtask

    task automatic send_column();
        send_word(make_word(ACT_COLUMN, $urandom_range(0, 63), $urandom_range(0, 3)));
    endtask

    // Quiet the request side, let every expected cell come out, then allow for
    // a start sweep or clearing pass still in progress.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MATCH:        match_cost = data;
            CFG_MISMATCH:     mismatch_cost = data;
            CFG_GAP_OPEN:     open_cost = data[GAP_W-1:0];
            CFG_GAP_EXTEND:   extend_cost = data[GAP_W-1:0];
            CFG_QUERY_LENGTH: rows_in_use = data;
            default:          ;
        endcase
    endtask

    // Gap registers get a random spare top bit; the block keeps only six bits.
    task automatic apply_settings(input int ms, input int mm, input int q, input int r,
                                  input int len);
        wait_idle();
        write_reg(CFG_MATCH, 7'(ms));
        write_reg(CFG_MISMATCH, 7'(mm));
        write_reg(CFG_GAP_OPEN, {1'($urandom), 6'(q)});
        write_reg(CFG_GAP_EXTEND, {1'($urandom), 6'(r)});
        write_reg(CFG_QUERY_LENGTH, 7'(len));
    endtask

    // Result side: random stalls unless a quiet stretch is on.
    always @(posedge clk)
        res_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // A cell is taken at the next rising edge when valid and ready are high now.
    always @(negedge clk)
    begin : check_cells
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_cells.size() == 0)
                report_mismatch($sformatf("cell with nothing pending: row %0d col %0d h %0d",
                                          res.row_index, res.column_index, res.cell_score));
            else
            begin
                want = expected_cells.pop_front();
                if (res.cell_score !== want.cell_score)
                    report_mismatch($sformatf("cell_score %0d, want %0d (row %0d col %0d)",
                                              res.cell_score, want.cell_score,
                                              want.row_index, want.column_index));
                if (res.row_index !== want.row_index)
                    report_mismatch($sformatf("row_index %0d, want %0d",
                                              res.row_index, want.row_index));
                if (res.column_index !== want.column_index)
                    report_mismatch($sformatf("column_index %0d, want %0d",
                                              res.column_index, want.column_index));
                if (res.last_row !== want.last_row)
                    report_mismatch($sformatf("last_row %0b, want %0b (row %0d)",
                                              res.last_row, want.last_row, want.row_index));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Column words straight after reset: H and E rows read as zero.
    // Only row 0 is in use, so only row 0 needs a symbol.
    task automatic test_before_start();
        int s;
        wait_idle();
        send_word(make_word(ACT_LOAD, 0, $urandom_range(0, 3)));
        send_word(make_word(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 3)));
        for (s = 0; s < 4; s++)
            send_word(make_word(ACT_COLUMN, $urandom_range(0, 63), s));
    endtask

    // Fill the whole query store so no later column reads an unwritten row.
    task automatic test_query_load();
        int idx;
        for (idx = 0; idx < QUERY_MAX_DEF; idx++)
            send_word(make_word(ACT_LOAD, idx, (idx < 4) ? idx : $urandom_range(0, 3)));
    endtask

    task automatic run_setting(input int ms, input int mm, input int q, input int r,
                               input int len);
        apply_settings(ms, mm, q, r, len);
        send_word(make_word(ACT_START, $urandom_range(0, 63), $urandom_range(0, 3)));
        send_column();
        send_column();
    endtask

    // Register extremes, length 0 and length above the store size.
    task automatic test_extremes();
        run_setting(63, 63, 63, 63, 127);
        run_setting(-64, -64, 0, 0, 64);
        run_setting(-64, 63, 63, 0, 0);
        send_word(make_word(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 3)));
        send_column();
        run_setting(0, 1, 0, 63, 64);
        run_setting(0, 1, 1, 1, 1);
    endtask

    // Random phases: each one a fresh setting, a start, then mostly columns
    // mixed with reloads, restarts and dropped words. Phase 2 runs with no idling.
    task automatic test_random_traffic();
        int phase;
        int n;
        int roll;
        int len;
        for (phase = 0; phase < 4; phase++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       len = 0;
                    1:       len = QUERY_MAX_DEF;
                    2:       len = 127;
                    default: len = $urandom_range(13, 127);
                endcase
            end
            else
                len = $urandom_range(1, 12);
            apply_settings($urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(0, 63), $urandom_range(0, 63), len);
            no_idle = (phase == 2);
            send_word(make_word(ACT_START, $urandom_range(0, 63), $urandom_range(0, 3)));
            for (n = 0; n < 14; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 72)
                    send_column();
                else if (roll < 84)
                    send_word(make_word(ACT_LOAD, $urandom_range(0, 63),
                                        $urandom_range(0, 3)));
                else if (roll < 92)
                    send_word(make_word(ACT_START, $urandom_range(0, 63),
                                        $urandom_range(0, 3)));
                else
                    send_word(make_word(ACT_UNUSED, $urandom_range(0, 63),
                                        $urandom_range(0, 3)));
            end
            no_idle = 1'b0;
        end
    endtask

    // Single-row run with top costs and no idling, then the column counter
    // keeps counting across a change to cheap matches and long gaps.
    task automatic test_single_row_run();
        int n;
        no_idle = 1'b1;
        apply_settings(63, 63, 63, 63, 1);
        send_word(make_word(ACT_START, $urandom_range(0, 63), $urandom_range(0, 3)));
        for (n = 0; n < RUN_COLUMNS; n++)
            send_column();
        no_idle = 1'b0;
        apply_settings(-64, 63, 0, 63, 1);
        for (n = 0; n < RUN_COLUMNS; n++)
            send_column();
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int i;
        for (i = 0; i < QUERY_MAX_DEF; i++)
        begin
            query_sym[i] = '0;
            h_col[i] = 0;
            e_col[i] = 0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_before_start();
        test_query_load();
        test_extremes();
        test_random_traffic();
        test_single_row_run();

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/agga_pkg.sv
hw/rtl/affine_gap_global_alignment.sv
verif/tb.sv
